// ===== rtl/assert_macros.svh =====
// assertion macros used by the window statistics core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clk edge, off while arst_n is low
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// implication checked on every clk edge, off while arst_n is low
`define ASSERT_IMPLY(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

`endif

// ===== rtl/mcws_pkg.sv =====
// shared constants and types of the multichannel window statistics core
package mcws_pkg;

	// sample and register field widths
	localparam int SAMPLE_W   = 16;
	localparam int CH_REG_W   = 4;
	localparam int FR_REG_W   = 11;
	localparam int CFG_W      = 11;
	localparam int CFG_IDX_W  = 2;

	// default sizes of the sample store
	localparam int MAX_CHANNELS_DEF = 8;
	localparam int MAX_WINDOW_DEF   = 1024;

	// register values after reset
	localparam int CH_RESET  = 2;
	localparam int WIN_RESET = 1024;

	// q1.15 extremes used to start peak and minimum
	localparam logic signed [SAMPLE_W-1:0] Q15_MIN = 16'sh8000;
	localparam logic signed [SAMPLE_W-1:0] Q15_MAX = 16'sh7fff;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CHANNEL_COUNT = 2'd0,
		REG_WINDOW_FRAMES = 2'd1
	} reg_idx_t;

endpackage

// ===== rtl/mcws_ram.sv =====
// generic simple dual port ram with registered read
module mcws_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/mcws_div.sv =====
// restoring divider, one quotient bit a cycle, truncates toward zero
module mcws_div import mcws_pkg::*; #(
	parameter int NUM_W = 30,
	parameter int DEN_W = 14
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic signed [NUM_W-1:0]    num,
	input  logic        [DEN_W-1:0]    den,
	output logic                       done,
	output logic signed [SAMPLE_W-1:0] quo
);

	localparam int SW = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic             neg_q;
	logic [NUM_W-1:0] mag_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [SW-1:0]    step_q;
	logic [DEN_W:0]   trial;
	logic             fits;
	logic [NUM_W-1:0] signed_q;

	// next partial remainder and quotient bit
	always_comb begin
		trial = {rem_q, mag_q[NUM_W-1]};
		fits  = (trial >= {1'b0, den_q});
	end

	// iterate over the dividend bits, msb first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= SW'(NUM_W);
				neg_q  <= num[NUM_W-1];
				mag_q  <= num[NUM_W-1] ? (~num + NUM_W'(1)) : num;
				rem_q  <= '0;
				den_q  <= den;
			end else if (busy_q) begin
				rem_q  <= fits ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
				mag_q  <= {mag_q[NUM_W-2:0], fits};
				step_q <= step_q - SW'(1);
				if (step_q == SW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// restore the sign of the quotient
	assign signed_q = neg_q ? (~mag_q + NUM_W'(1)) : mag_q;
	assign quo      = signed_q[SAMPLE_W-1:0];
	assign done     = done_q;

endmodule

// ===== rtl/multichannel_window_stats_core.sv =====
// Interleaved Q1.15 samples are routed by a rotating channel counter into
// per-channel circular windows held in one synchronous RAM. A sample without
// last_in_block is written while the input stays unstalled, and the next item
// can follow at once. A sample with last_in_block is written, then the core
// reads every active window entry through the RAM's single read port, one
// entry a cycle, and divides the sum in a restoring divider that yields one
// quotient bit a cycle (SUM_W = 30 dividend bits with the default sizes); the
// input stays stalled until the result is taken into the output register.
// Entries not written since reset or the last write to a configuration
// register read as zero through a fill tracker, so no clearing pass is needed.
// A finished result waits in an output register while new samples keep being
// accepted; a write to either configuration register restarts all windows.
`include "assert_macros.svh"

module multichannel_window_stats_core import mcws_pkg::*; #(
	parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
	parameter int MAX_WINDOW   = MAX_WINDOW_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration writes
	input  logic                       cfg_wen,
	input  logic [CFG_IDX_W-1:0]       cfg_addr,
	input  logic [CFG_W-1:0]           cfg_wdata,
	// sample items
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic                       last_in_block,
	// statistics items
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [SAMPLE_W-1:0] peak,
	output logic signed [SAMPLE_W-1:0] minimum,
	output logic signed [SAMPLE_W-1:0] average
);

	localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int FW     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CN_W   = $clog2(MAX_CHANNELS + 1);
	localparam int FN_W   = $clog2(MAX_WINDOW + 1);
	localparam int AW     = CH_W + FW;
	localparam int DEPTH  = 2 ** AW;
	localparam int CNT_W  = $clog2(MAX_CHANNELS * MAX_WINDOW + 1);
	localparam int SUM_W  = CNT_W + SAMPLE_W;
	localparam int NCH_RST = (CH_RESET > MAX_CHANNELS) ? MAX_CHANNELS : CH_RESET;
	localparam int NFR_RST = (WIN_RESET > MAX_WINDOW) ? MAX_WINDOW : WIN_RESET;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DIVGO,
		ST_DIV,
		ST_OUT
	} state_t;

	state_t                     state_q;
	logic [CN_W-1:0]            nch_q;
	logic [FN_W-1:0]            nfr_q;
	logic [CH_W-1:0]            cp_q;
	logic [FW-1:0]              wp_q;
	logic                       wrap_q;
	logic [CH_W-1:0]            sc_c_q;
	logic [FW-1:0]              sc_f_q;
	logic                       rd_s1;
	logic                       ok_s1;
	logic signed [SAMPLE_W-1:0] acc_peak_q;
	logic signed [SAMPLE_W-1:0] acc_min_q;
	logic signed [SUM_W-1:0]    acc_sum_q;
	logic [CNT_W-1:0]           count_q;
	logic signed [SAMPLE_W-1:0] avg_q;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] res_peak_q;
	logic signed [SAMPLE_W-1:0] res_min_q;
	logic signed [SAMPLE_W-1:0] res_avg_q;

	logic                       in_acc;
	logic [SAMPLE_W-1:0]        ram_rdata;
	logic signed [SAMPLE_W-1:0] rv;
	logic                       entry_ok;
	logic                       sc_c_end;
	logic                       sc_f_end;
	logic [CN_W-1:0]            nch_new;
	logic [FN_W-1:0]            nfr_new;
	int                         ch_i;
	int                         fr_i;
	logic                       div_start;
	logic                       div_done;
	logic signed [SAMPLE_W-1:0] div_quo;

	// handshake
	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;

	// clamp register writes into the supported range
	always_comb begin
		ch_i = int'(cfg_wdata[CH_REG_W-1:0]);
		fr_i = int'(cfg_wdata[FR_REG_W-1:0]);
		if (ch_i < 1) begin
			ch_i = 1;
		end else if (ch_i > MAX_CHANNELS) begin
			ch_i = MAX_CHANNELS;
		end
		if (fr_i < 1) begin
			fr_i = 1;
		end else if (fr_i > MAX_WINDOW) begin
			fr_i = MAX_WINDOW;
		end
		nch_new = CN_W'(ch_i);
		nfr_new = FN_W'(fr_i);
	end

	// configuration and write position tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nch_q  <= CN_W'(NCH_RST);
			nfr_q  <= FN_W'(NFR_RST);
			cp_q   <= '0;
			wp_q   <= '0;
			wrap_q <= 1'b0;
		end else if (cfg_wen) begin
			case (cfg_addr)
				REG_CHANNEL_COUNT: begin
					nch_q  <= nch_new;
					cp_q   <= '0;
					wp_q   <= '0;
					wrap_q <= 1'b0;
				end
				REG_WINDOW_FRAMES: begin
					nfr_q  <= nfr_new;
					cp_q   <= '0;
					wp_q   <= '0;
					wrap_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end else if (in_acc) begin
			if (CN_W'(cp_q) + CN_W'(1) == nch_q) begin
				cp_q <= '0;
				if (FN_W'(wp_q) + FN_W'(1) == nfr_q) begin
					wp_q   <= '0;
					wrap_q <= 1'b1;
				end else begin
					wp_q <= wp_q + FW'(1);
				end
			end else begin
				cp_q <= cp_q + CH_W'(1);
			end
		end
	end

	// scan position and fill check, unwritten entries count as zero
	assign sc_c_end = (CN_W'(sc_c_q) + CN_W'(1) == nch_q);
	assign sc_f_end = (FN_W'(sc_f_q) + FN_W'(1) == nfr_q);
	assign entry_ok = wrap_q || (sc_f_q < wp_q) || ((sc_f_q == wp_q) && (sc_c_q < cp_q));
	assign rv       = ok_s1 ? $signed(ram_rdata) : '0;

	// sample store
	mcws_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (in_acc),
		.waddr ({cp_q, wp_q}),
		.wdata (sample),
		.re    (state_q == ST_SCAN),
		.raddr ({sc_c_q, sc_f_q}),
		.rdata (ram_rdata)
	);

	// mean divider
	assign div_start = (state_q == ST_DIVGO);

	mcws_div #(
		.NUM_W (SUM_W),
		.DEN_W (CNT_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (acc_sum_q),
		.den    (count_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	// scan sequencer, accumulators and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_s1 <= (state_q == ST_SCAN);
			ok_s1 <= entry_ok;
			if (out_valid_q && !out_stall && (state_q != ST_OUT)) begin
				out_valid_q <= 1'b0;
			end
			// fold in the entry read in the previous cycle
			if (rd_s1) begin
				if (rv > acc_peak_q) begin
					acc_peak_q <= rv;
				end
				if (rv < acc_min_q) begin
					acc_min_q <= rv;
				end
				acc_sum_q <= acc_sum_q + SUM_W'(rv);
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc && last_in_block) begin
						state_q    <= ST_SCAN;
						sc_c_q     <= '0;
						sc_f_q     <= '0;
						acc_peak_q <= Q15_MIN;
						acc_min_q  <= Q15_MAX;
						acc_sum_q  <= '0;
						count_q    <= CNT_W'(nch_q) * CNT_W'(nfr_q);
					end
				end
				ST_SCAN: begin
					if (sc_f_end) begin
						sc_f_q <= '0;
						if (sc_c_end) begin
							state_q <= ST_DRAIN;
						end else begin
							sc_c_q <= sc_c_q + CH_W'(1);
						end
					end else begin
						sc_f_q <= sc_f_q + FW'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DIVGO;
				end
				ST_DIVGO: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						avg_q   <= div_quo;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						res_peak_q  <= acc_peak_q;
						res_min_q   <= acc_min_q;
						res_avg_q   <= avg_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign peak      = res_peak_q;
	assign minimum   = res_min_q;
	assign average   = res_avg_q;

	// checks
	`ASSERT_CLK(a_pos_range, (CN_W'(cp_q) < nch_q) && (FN_W'(wp_q) < nfr_q), "write position outside window")
	`ASSERT_IMPLY(a_scan_range, state_q == ST_SCAN, (CN_W'(sc_c_q) < nch_q) && (FN_W'(sc_f_q) < nfr_q), "scan outside window")
	`ASSERT_IMPLY(a_div_done, div_done, state_q == ST_DIV, "divider finished outside its wait state")
	`ASSERT_IMPLY(a_mean_bound, out_valid_q, (res_avg_q >= res_min_q) && (res_avg_q <= res_peak_q), "mean outside minimum and peak")

endmodule
